### rtl/lzss_pkg.sv
// Shared constants, token type and widths for the LZSS bit-stream decompressor.
// Depends on nothing; every other file in rtl/ imports it.
package lzss_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_CFG_W  = 24;
    localparam int DICT_SIZE  = 8192;
    localparam int ADDR_W     = $clog2(DICT_SIZE);
    localparam int FILL_W     = ADDR_W + 1;
    localparam int OFF_W      = 13;
    localparam int LEN_W      = 4;
    localparam int MIN_MATCH  = 3;

    // Token sizes in stream bits, and the widest bit buffer they need.
    localparam int LIT_BITS   = 1 + BYTE_W;
    localparam int TOKEN_BITS = 1 + OFF_W + LEN_W;
    localparam int BUF_W      = TOKEN_BITS - 1 + BYTE_W;
    localparam int CNT_W      = $clog2(BUF_W + 1);

    // Bytes produced by one token.
    localparam int MAX_RUN    = (1 << LEN_W) - 1 + MIN_MATCH;
    localparam int RUN_W      = $clog2(MAX_RUN + 1);

    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);

    // One decoded token on its way from the parser to the copy engine.
    // arg holds the literal in its low bits, or the copy position.
    typedef struct packed {
        logic             is_lit;
        logic [OFF_W-1:0] arg;
        logic [RUN_W-1:0] run;
        logic             last;
        logic             done;
    } token_t;

endpackage

### rtl/lzss_bitstream_decompressor.sv
// LZSS bit-stream decompressor: one compressed word in, decompressed words out.
// The stream is read most significant bit first; a 1 flag bit is followed by an
// 8-bit literal, a 0 flag bit by a 13-bit ring position and a 4-bit count (plus
// three bytes). Every decoded byte goes into an 8192-byte history ring, whose
// write head starts at 1, and is delivered with run_last on the final byte that
// an input word causes and file_done on byte number output_length. Writing
// output_length re-arms the block at once; there is no clearing pass, since a
// fill count makes unwritten ring entries read as zero. After the length is
// reached, input words are taken and dropped until the next write. Timing: an
// input word is taken whenever the parser holds no complete token; the parser
// then splits off one token per cycle into a four-entry queue while it is not
// full. The copy engine delivers one byte per cycle while the output is not
// stalled; a literal is emitted as it is popped, while a copy first waits for
// the registered read of the ring's first position.
module lzss_bitstream_decompressor
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lzss_pkg::LEN_CFG_W-1:0] output_length,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lzss_pkg::BYTE_W-1:0]    in_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lzss_pkg::BYTE_W-1:0]    out_byte,
    output logic                           run_last,
    output logic                           file_done
);
    import lzss_pkg::*;

    token_t push_tok;
    token_t pop_tok;
    logic   q_push;
    logic   q_pop;
    logic   q_full;
    logic   q_valid;

    // Front: take words, parse tokens, trim the last token to the length.
    lzss_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .output_length (output_length),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_tok         (push_tok)
    );

    // Queue: decouple parsing from copying; flush on re-arm.
    lzss_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .flush  (cfg_we),
        .push   (q_push),
        .wr_tok (push_tok),
        .pop    (q_pop),
        .full   (q_full),
        .valid  (q_valid),
        .rd_tok (pop_tok)
    );

    // Back: play tokens against the ring and hold the output word.
    lzss_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (cfg_we),
        .q_valid   (q_valid),
        .q_tok     (pop_tok),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .file_done (file_done)
    );

`ifndef SYNTHESIS
    // never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("token pushed into full queue");

    // never pop an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("token popped from empty queue");

    // the byte that ends the file also ends its input word's run
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && file_done) |-> run_last)
        else $error("file_done without run_last");
`endif

endmodule

### rtl/lzss_front.sv
// Token parser: gathers input words into a bit buffer, splits off literal and
// copy tokens, and trims the final token to the configured length. Uses lzss_pkg.
module lzss_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lzss_pkg::LEN_CFG_W-1:0] output_length,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [lzss_pkg::BYTE_W-1:0]    in_byte,
    input  logic                           q_full,
    output logic                           q_push,
    output lzss_pkg::token_t               q_tok
);
    import lzss_pkg::*;

    logic [LEN_CFG_W-1:0] length_reg;
    logic [LEN_CFG_W-1:0] emitted_reg, emitted_next;
    logic [BUF_W-1:0]     buf_reg, buf_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 finished_reg, finished_next;

    logic                 flag;
    logic [CNT_W-1:0]     need;
    logic                 tok_ready;
    logic [LEN_W-1:0]     len_field;
    logic [RUN_W-1:0]     run_raw;
    logic [LEN_CFG_W-1:0] remaining;
    logic                 hit;
    logic [BUF_W-1:0]     buf_sh;
    logic [CNT_W-1:0]     cnt_sh;
    logic                 next_ready;
    logic                 accept;

    // Oldest stream bit sits at the top of the buffer.
    assign flag      = buf_reg[BUF_W-1];
    assign need      = flag ? CNT_W'(LIT_BITS) : CNT_W'(TOKEN_BITS);
    assign tok_ready = !finished_reg && (cnt_reg >= need);
    assign in_stall  = tok_ready;
    assign accept    = in_valid && !in_stall;

    assign len_field = buf_reg[BUF_W-2-OFF_W -: LEN_W];
    assign run_raw   = flag ? RUN_W'(1) : RUN_W'(len_field) + RUN_W'(MIN_MATCH);
    assign remaining = length_reg - emitted_reg;
    assign hit       = LEN_CFG_W'(run_raw) >= remaining;

    assign buf_sh     = buf_reg << need;
    assign cnt_sh     = cnt_reg - need;
    assign next_ready = (cnt_sh >= (buf_sh[BUF_W-1] ? CNT_W'(LIT_BITS) : CNT_W'(TOKEN_BITS)));

    assign q_push      = tok_ready && !q_full;
    assign q_tok.is_lit = flag;
    assign q_tok.arg   = flag ? OFF_W'(buf_reg[BUF_W-2 -: BYTE_W])
                              : buf_reg[BUF_W-2 -: OFF_W];
    assign q_tok.run   = hit ? RUN_W'(remaining) : run_raw;
    assign q_tok.last  = hit || !next_ready;
    assign q_tok.done  = hit;

    always_comb
    begin
        emitted_next  = emitted_reg;
        buf_next      = buf_reg;
        cnt_next      = cnt_reg;
        finished_next = finished_reg;
        if (q_push)
        begin
            emitted_next = emitted_reg + LEN_CFG_W'(q_tok.run);
            if (hit)
            begin
                // length reached: drop whatever bits are left
                finished_next = 1'b1;
                buf_next      = '0;
                cnt_next      = '0;
            end
            else
            begin
                buf_next = buf_sh;
                cnt_next = cnt_sh;
            end
        end
        else if (accept && !finished_reg)
        begin
            if (emitted_reg >= length_reg)
            begin
                finished_next = 1'b1;
                buf_next      = '0;
                cnt_next      = '0;
            end
            else
            begin
                buf_next = buf_reg | ({in_byte, {(BUF_W-BYTE_W){1'b0}}} >> cnt_reg);
                cnt_next = cnt_reg + CNT_W'(BYTE_W);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= '0;
            emitted_reg  <= '0;
            buf_reg      <= '0;
            cnt_reg      <= '0;
            finished_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            length_reg   <= output_length;
            emitted_reg  <= '0;
            buf_reg      <= '0;
            cnt_reg      <= '0;
            finished_reg <= 1'b0;
        end
        else
        begin
            emitted_reg  <= emitted_next;
            buf_reg      <= buf_next;
            cnt_reg      <= cnt_next;
            finished_reg <= finished_next;
        end
    end

endmodule

### rtl/lzss_queue.sv
// Short token queue between the parser and the copy engine.
// Uses lzss_pkg for the token type and depth.
module lzss_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             flush,
    input  logic             push,
    input  lzss_pkg::token_t wr_tok,
    input  logic             pop,
    output logic             full,
    output logic             valid,
    output lzss_pkg::token_t rd_tok
);
    import lzss_pkg::*;

    token_t          slot_reg [Q_DEPTH];
    logic [Q_AW-1:0] wptr_reg, rptr_reg;
    logic [Q_AW:0]   count_reg;

    assign full   = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign valid  = (count_reg != '0);
    assign rd_tok = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= wr_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else if (flush)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/lzss_back.sv
// Copy engine: carries out literal and copy tokens against the history ring and
// drives the output word register. Holds the ring memory. Uses lzss_pkg.
module lzss_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        flush,
    input  logic                        q_valid,
    input  lzss_pkg::token_t            q_tok,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [lzss_pkg::BYTE_W-1:0] out_byte,
    output logic                        run_last,
    output logic                        file_done
);
    import lzss_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_COPY = 2'b10
    } state_t;

    logic [BYTE_W-1:0] ring_mem [DICT_SIZE];

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] head_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [RUN_W-1:0]  left_reg, left_next;
    logic              last_reg, last_next;
    logic              done_reg, done_next;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              rd_valid_reg, rd_valid_next;
    logic              byp_reg, byp_next;
    logic [BYTE_W-1:0] byp_data_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              run_last_reg;
    logic              file_done_reg;

    logic              out_free;
    logic              emit;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_last;
    logic              emit_done;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] copy_byte;
    logic              final_byte;

    assign out_free   = !out_valid_reg || !out_stall;
    // entry never written since arming reads as zero
    assign copy_byte  = byp_reg ? byp_data_reg : (rd_valid_reg ? rd_data_reg : '0);
    assign final_byte = (left_reg == RUN_W'(1));

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        left_next  = left_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        emit       = 1'b0;
        emit_byte  = copy_byte;
        emit_last  = 1'b0;
        emit_done  = 1'b0;
        q_pop      = 1'b0;
        rd_addr    = pos_reg;
        byp_next   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_tok.is_lit)
                    begin
                        if (out_free)
                        begin
                            q_pop     = 1'b1;
                            emit      = 1'b1;
                            emit_byte = q_tok.arg[BYTE_W-1:0];
                            emit_last = q_tok.last;
                            emit_done = q_tok.done;
                        end
                    end
                    else
                    begin
                        q_pop      = 1'b1;
                        pos_next   = ADDR_W'(q_tok.arg);
                        left_next  = q_tok.run;
                        last_next  = q_tok.last;
                        done_next  = q_tok.done;
                        rd_addr    = pos_next;
                        state_next = ST_COPY;
                    end
                end
            end
            ST_COPY:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_last = final_byte && last_reg;
                    emit_done = final_byte && done_reg;
                    pos_next  = pos_reg + 1'b1;
                    left_next = left_reg - 1'b1;
                    rd_addr   = pos_next;
                    // the next byte is the one written this cycle
                    byp_next  = (pos_next == head_reg);
                    if (final_byte)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_valid_next = fill_reg[ADDR_W] ||
                           ((rd_addr != '0) && (FILL_W'(rd_addr) <= fill_reg));

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ring_mem[head_reg] <= emit_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg  <= ring_mem[rd_addr];
        rd_valid_reg <= rd_valid_next;
        byp_data_reg <= emit_byte;
        pos_reg      <= pos_next;
        left_reg     <= left_next;
        last_reg     <= last_next;
        done_reg     <= done_next;
        if (emit)
        begin
            out_byte_reg  <= emit_byte;
            run_last_reg  <= emit_last;
            file_done_reg <= emit_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= ADDR_W'(1);
            fill_reg      <= '0;
            byp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (flush)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= ADDR_W'(1);
            fill_reg      <= '0;
            byp_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            byp_reg   <= byp_next;
            if (emit)
            begin
                head_reg <= head_reg + 1'b1;
                if (fill_reg != FILL_W'(DICT_SIZE))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign file_done = file_done_reg;

endmodule

### tb/lzss_stream_checker.sv
`timescale 1ns / 1ps
// Stream checker for the LZSS bit-stream decompressor: watches the register write,
// the input and output channels, decodes accepted words and compares each result.
// Depends on lzss_pkg for widths; instantiated beside the block by the testbench top.
module lzss_stream_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lzss_pkg::LEN_CFG_W-1:0] output_length,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [lzss_pkg::BYTE_W-1:0]    in_byte,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [lzss_pkg::BYTE_W-1:0]    out_byte,
    input  logic                           run_last,
    input  logic                           file_done,
    output int                             mismatches,
    output int                             awaiting
);

    localparam int LIT_LEN     = 1 + lzss_pkg::BYTE_W;
    localparam int COPY_LEN    = lzss_pkg::TOKEN_BITS;
    localparam int OFFSET_BITS = lzss_pkg::OFF_W;
    localparam int MIN_RUN     = lzss_pkg::MIN_MATCH;

    typedef struct packed {
        logic [lzss_pkg::BYTE_W-1:0] data;
        logic                        last;
        logic                        done;
    } decoded_t;

    decoded_t expected_bytes[$];
    decoded_t held;
    logic     have_held;

    // Shadow copy of the block's state
    logic [lzss_pkg::BYTE_W-1:0]    history [lzss_pkg::DICT_SIZE];
    logic [lzss_pkg::ADDR_W-1:0]    head;
    logic [lzss_pkg::LEN_CFG_W-1:0] pend_bits;
    int unsigned                    pend_cnt;
    logic [lzss_pkg::LEN_CFG_W-1:0] emitted;
    logic                           finished;
    logic [lzss_pkg::LEN_CFG_W-1:0] out_len;

    initial mismatches = 0;
    initial awaiting = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got 0x%02h, wanted 0x%02h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic rearm(input logic [lzss_pkg::LEN_CFG_W-1:0] len);
        out_len = len;
        foreach (history[i]) history[i] = '0;
        head      = 1;
        pend_bits = '0;
        pend_cnt  = 0;
        emitted   = '0;
        finished  = 1'b0;
    endtask

    // Queue the previous byte and hold this one, so the final byte of a word can be marked.
    task automatic emit_byte(input logic [lzss_pkg::BYTE_W-1:0] value, output logic reached);
        history[head] = value;
        head          = head + 1'b1;
        emitted       = emitted + 1'b1;
        if (have_held)
            expected_bytes.push_back(held);
        held      = '{data: value, last: 1'b0, done: (emitted == out_len)};
        have_held = 1'b1;
        reached   = (emitted >= out_len);
    endtask

    task automatic decode_word(input logic [lzss_pkg::BYTE_W-1:0] word);
        logic [31:0]                 acc;
        int unsigned                 cnt;
        logic                        stop;
        logic [lzss_pkg::ADDR_W-1:0] pos;
        int unsigned                 run;
        if (finished)
            return;
        if (emitted >= out_len)
        begin
            finished  = 1'b1;
            pend_bits = '0;
            pend_cnt  = 0;
            return;
        end
        acc       = {pend_bits, word};
        cnt       = pend_cnt + 8;
        stop      = 1'b0;
        have_held = 1'b0;
        while (!stop && cnt >= 1)
        begin
            if (acc[cnt-1])
            begin
                if (cnt < LIT_LEN)
                    break;
                emit_byte(8'(acc >> (cnt - LIT_LEN)), stop);
                cnt -= LIT_LEN;
            end
            else
            begin
                if (cnt < COPY_LEN)
                    break;
                pos = lzss_pkg::ADDR_W'(acc >> (cnt - 1 - OFFSET_BITS));
                run = 32'(4'(acc >> (cnt - COPY_LEN))) + MIN_RUN;
                cnt -= COPY_LEN;
                for (int k = 0; k < run && !stop; k++)
                begin
                    emit_byte(history[pos], stop);
                    pos = pos + 1'b1;
                end
            end
        end
        if (stop)
        begin
            finished  = 1'b1;
            pend_bits = '0;
            pend_cnt  = 0;
        end
        else
        begin
            pend_cnt  = cnt;
            pend_bits = 24'(acc & ((32'd1 << cnt) - 1));
        end
        if (have_held)
        begin
            held.last = 1'b1;
            expected_bytes.push_back(held);
        end
    endtask

    always @(posedge clk)
    begin
        decoded_t want;
        if (!rst_n)
        begin
            expected_bytes.delete();
            rearm('0);
        end
        else
        begin
            // Compare first: a word taken at this edge cannot have caused this result
            if (out_valid && !out_stall)
            begin
                if (expected_bytes.size() == 0)
                    report_mismatch("unexpected out_byte", out_byte, 0);
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch("out_byte", out_byte, want.data);
                    if (run_last !== want.last)
                        report_mismatch("run_last", run_last, want.last);
                    if (file_done !== want.done)
                        report_mismatch("file_done", file_done, want.done);
                end
            end
            if (cfg_we)
                rearm(output_length);
            if (in_valid && !in_stall)
                decode_word(in_byte);
        end
        awaiting = expected_bytes.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the LZSS bit-stream decompressor: builds token streams, drives
// both channels and the length register, and gives the verdict from lzss_stream_checker.
// Depends on lzss_pkg, the block itself and tb/lzss_stream_checker.sv.
module testbench;

    // Generous cap on the length of the whole run
    localparam int CYCLE_LIMIT   = 500000;
    // Drain time once nothing is expected: covers words still being parsed or dropped
    localparam int SETTLE_CYCLES = 64;
    // Random words per idling pattern
    localparam int WORDS_PER_MODE = 25;

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           cfg_we        = 1'b0;
    logic [lzss_pkg::LEN_CFG_W-1:0] output_length = '0;
    logic                           in_valid      = 1'b0;
    logic                           in_stall;
    logic [lzss_pkg::BYTE_W-1:0]    in_byte       = '0;
    logic                           out_valid;
    logic                           out_stall     = 1'b0;
    logic [lzss_pkg::BYTE_W-1:0]    out_byte;
    logic                           run_last;
    logic                           file_done;

    int mismatches;
    int awaiting;
    int cycle_count    = 0;
    int words_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Token stream under construction, most significant bit first
    bit                          stream_bits[$];
    // Where the block's write head will be, so copies can aim at recent history
    logic [lzss_pkg::ADDR_W-1:0] gen_head;
    int                          gen_total;

    lzss_bitstream_decompressor DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .output_length (output_length),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .run_last      (run_last),
        .file_done     (file_done)
    );

    lzss_stream_checker stream_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .output_length (output_length),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .run_last      (run_last),
        .file_done     (file_done),
        .mismatches    (mismatches),
        .awaiting      (awaiting)
    );

    always #5 clk = ~clk;

    // Receiver back-pressure: re-draw the stall at every falling edge
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Watchdog: a hung block or a lost result ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Offer one word, with random gaps ahead of it, and hold it until taken.
    // Called and returns at a falling edge; valid stays high for a following word.
    task automatic send_word(input logic [lzss_pkg::BYTE_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    // Drop valid, wait for every expected result, then let the block drain.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (awaiting != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // Write the length register; only ever called while the block is idle.
    task automatic program_length(input logic [lzss_pkg::LEN_CFG_W-1:0] len);
        output_length <= len;
        cfg_we        <= 1'b1;
        @(negedge clk);
        cfg_we        <= 1'b0;
    endtask

    task automatic start_stream();
        stream_bits.delete();
        gen_head  = 1;
        gen_total = 0;
    endtask

    task automatic push_field(input logic [31:0] value, input int width);
        for (int i = width - 1; i >= 0; i--)
            stream_bits.push_back(value[i]);
    endtask

    task automatic add_literal(input logic [lzss_pkg::BYTE_W-1:0] value);
        push_field(1, 1);
        push_field(value, lzss_pkg::BYTE_W);
        gen_head  = gen_head + 1'b1;
        gen_total = gen_total + 1;
    endtask

    task automatic add_copy(input logic [lzss_pkg::OFF_W-1:0] pos,
                            input logic [lzss_pkg::LEN_W-1:0] count);
        push_field(0, 1);
        push_field(pos, lzss_pkg::OFF_W);
        push_field(count, lzss_pkg::LEN_W);
        gen_head  = gen_head + lzss_pkg::ADDR_W'(count + lzss_pkg::MIN_MATCH);
        gen_total = gen_total + count + lzss_pkg::MIN_MATCH;
    endtask

    // Mostly copies from the last couple of dozen bytes; some one-byte runs,
    // some reads just ahead of the head (still zero) and some anywhere in the ring.
    task automatic add_random_token();
        int                          pick;
        logic [lzss_pkg::OFF_W-1:0]  pos;
        pick = $urandom_range(99);
        if (pick < 40)
            add_literal(8'($urandom_range(255)));
        else
        begin
            if (pick < 75)
                pos = gen_head - 13'($urandom_range(1, 24));
            else if (pick < 85)
                pos = gen_head - 1'b1;
            else if (pick < 90)
                pos = gen_head;
            else
                pos = 13'($urandom_range(8191));
            add_copy(pos, 4'($urandom_range(15)));
        end
    endtask

    // Pad the stream to whole words with random bits and send it.
    // pause_after >= 0: hold off before that word until every result is back.
    task automatic send_stream(input int pause_after);
        logic [lzss_pkg::BYTE_W-1:0] word;
        int                          idx;
        word = '0;
        while (stream_bits.size() % 8 != 0)
            stream_bits.push_back(1'($urandom_range(1)));
        idx = 0;
        while (stream_bits.size() != 0)
        begin
            for (int i = 0; i < 8; i++)
                word = {word[6:0], stream_bits.pop_front()};
            if (idx == pause_after)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
                while (awaiting != 0)
                    @(negedge clk);
            end
            send_word(word);
            idx++;
        end
    endtask

    // One well-formed file with random content; the length either matches the
    // stream, cuts it short (often inside a copy), outruns it, or is zero.
    task automatic random_file();
        int          pick;
        int unsigned len;
        start_stream();
        repeat ($urandom_range(1, 6))
            add_random_token();
        pick = $urandom_range(99);
        if (pick < 55)
            len = gen_total;
        else if (pick < 80)
            len = $urandom_range(1, gen_total);
        else if (pick < 93)
            len = gen_total + $urandom_range(1, 40);
        else
            len = 0;
        program_length(24'(len));
        send_stream(-1);
        // Trailing words: dropped once the file is complete, else parsed as further tokens
        repeat ($urandom_range(0, 2))
            send_word(8'($urandom_range(255)));
        settle();
    endtask

    // Broken stream: arbitrary words parsed as whatever tokens they form.
    task automatic noise_file();
        program_length(24'($urandom_range(1, 60)));
        repeat ($urandom_range(3, 8))
            send_word(8'($urandom_range(255)));
        settle();
    endtask

    initial
    begin
        int mode_start;

        send_idle_pct  = 32;
        recv_stall_pct = 50;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(negedge clk);

        // Length at its reset value of zero: the first word finishes the file
        // without a result, the second is dropped
        send_word(8'hFF);
        send_word(8'h00);
        settle();

        // Zero length written explicitly
        program_length('0);
        send_word(8'hA5);
        settle();

        // Longest length: literal extremes, copy from position zero with the
        // shortest count, an overlapping run, a copy from the top of the ring
        // wrapping to zero, and a pause for all results partway through
        program_length(24'hFF_FFFF);
        start_stream();
        add_literal(8'h00);
        add_literal(8'hFF);
        add_copy(13'd0, 4'd0);
        add_copy(gen_head - 1'b1, 4'd15);
        add_copy(13'h1FFF, 4'd15);
        add_literal(8'h5A);
        send_stream(4);
        settle();

        // Length reached inside a copy: the rest of the copy, the literal behind
        // it and the trailing words are all dropped
        program_length(24'd5);
        start_stream();
        add_literal(8'h11);
        add_copy(gen_head - 1'b1, 4'd15);
        add_literal(8'h22);
        send_stream(-1);
        send_word(8'h80);
        send_word(8'h7F);
        settle();

        // Random files under three idling patterns: sender light and receiver
        // heavy, the reverse, then no idling at all
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct  = (mode == 0) ? 32 : (mode == 1) ? 50 : 0;
            recv_stall_pct = (mode == 0) ? 50 : (mode == 1) ? 32 : 0;
            mode_start = words_sent;
            while (words_sent - mode_start < WORDS_PER_MODE)
            begin
                if ($urandom_range(99) < 15)
                    noise_file();
                else
                    random_file();
            end
        end

        settle();
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
